// ----- rtl/mtg_pkg.sv -----
// package for the mt19937 generator: states, request codes, constants
// and the tempering function
// no dependencies
`default_nettype none

package mtg_pkg;

	// request codes carried on s_tuser
	localparam logic [1:0] FUNC_WORD   = 2'd0;
	localparam logic [1:0] FUNC_FRAC   = 2'd1;
	localparam logic [1:0] FUNC_RESEED = 2'd2;

	// generator constants
	localparam int unsigned  N_WORDS      = 624;
	localparam int unsigned  M_SHIFT      = 397;
	localparam logic [9:0]   LAST_IDX     = 10'd623;
	localparam logic [9:0]   POS_END      = 10'd624;
	localparam logic [9:0]   FAR_UP       = 10'd397;
	localparam logic [9:0]   FAR_DOWN     = 10'd227;
	localparam logic [31:0]  TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0]  SEED_MULT    = 32'd1812433253;
	localparam logic [31:0]  RESET_SEED   = 32'd42424242;
	localparam logic [31:0]  TEMPER_B     = 32'h9d2c5680;
	localparam logic [31:0]  TEMPER_C     = 32'hefc60000;

	typedef enum logic [2:0] {
		ST_SEED,
		ST_IDLE,
		ST_DRAW,
		ST_TW_PRIME,
		ST_TW_RUN,
		ST_FETCH,
		ST_OUT
	} state_t;

	// output tempering of one state word
	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mt19937_generator_unit.sv -----
// mt19937 generator top level: state memory, seeding, bulk twist and tempering
// depends on mtg_pkg
`default_nettype none

// MT19937 generator. The 624-word state sits in one synchronous memory with
// two read ports and one write port. After reset the block fills the memory
// from seed 42424242, one word per cycle, and accepts nothing until the fill
// is done. Each draw reads the memory in ST_DRAW and tempers the word in
// ST_FETCH; a word result takes one draw and a fraction result two, and the
// result is then loaded into the output register in ST_OUT. The block takes
// a new request only in ST_IDLE, once the last result has been loaded.
// Whenever the read position has run out, the next draw first regenerates all
// 624 words, one word per cycle through the memory. A reseed request refills
// the memory the same way as after reset and returns value 0 once the fill
// is done. The reads of a twist step never hit the word being written in
// the same cycle, so the twist needs no forwarding.
// A finished result waits in the output register while the block takes the
// next request.
module mt19937_generator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] seed_value
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata    // [52:0] value, [84:53] current_seed
);

	mtg_pkg::state_t state_q, state_d;

	// state memory
	logic [31:0] mem [mtg_pkg::N_WORDS];
	logic [9:0]  rd_a_addr, rd_b_addr, wr_addr;
	logic        wr_en;
	logic [31:0] wr_data;
	logic [31:0] rd_a_q, rd_b_q;

	// control and datapath registers
	logic [9:0]  pos_q;
	logic [9:0]  sd_q;
	logic [31:0] w_q;
	logic [31:0] seed_q;
	logic        req_q;
	logic [1:0]  func_q;
	logic        sec_q;
	logic [26:0] a_q;
	logic [52:0] res_q;
	logic [9:0]  iss_q;
	logic        prime_s1;
	logic        tv_s1;
	logic [9:0]  idx_s1;
	logic [31:0] cur_q;
	logic        m_tvalid_q;
	logic [87:0] m_tdata_q;

	logic        out_free;
	logic        issue;
	logic [9:0]  iss_nxt, iss_far;
	logic [31:0] tw_y, tw_new;
	logic [31:0] seed_prod, seed_next;
	logic [31:0] tempered;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// twist step addresses
	assign issue   = (state_q == mtg_pkg::ST_TW_RUN) && (iss_q < mtg_pkg::POS_END);
	assign iss_nxt = (iss_q >= mtg_pkg::LAST_IDX) ? 10'd0 : iss_q + 10'd1;
	assign iss_far = (iss_q < mtg_pkg::FAR_DOWN) ? iss_q + mtg_pkg::FAR_UP
	                                             : iss_q - mtg_pkg::FAR_DOWN;

	// twist step datapath: cur is old w[i], port a gives w[i+1], port b w[far]
	assign tw_y   = {cur_q[31], rd_a_q[30:0]};
	assign tw_new = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);

	// seeding recurrence
	assign seed_prod = 32'(mtg_pkg::SEED_MULT * (w_q ^ (w_q >> 30)));
	assign seed_next = seed_prod + {22'd0, sd_q} + 32'd1;

	assign tempered = mtg_pkg::temper(rd_a_q);

	// state memory ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtg_pkg::ST_SEED: begin
				if (sd_q == mtg_pkg::LAST_IDX) begin
					state_d = req_q ? mtg_pkg::ST_OUT : mtg_pkg::ST_IDLE;
				end
			end
			mtg_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						mtg_pkg::FUNC_WORD, mtg_pkg::FUNC_FRAC: state_d = mtg_pkg::ST_DRAW;
						mtg_pkg::FUNC_RESEED: state_d = mtg_pkg::ST_SEED;
						default: state_d = mtg_pkg::ST_OUT;
					endcase
				end
			end
			mtg_pkg::ST_DRAW: begin
				state_d = (pos_q >= mtg_pkg::POS_END) ? mtg_pkg::ST_TW_PRIME
				                                      : mtg_pkg::ST_FETCH;
			end
			mtg_pkg::ST_TW_PRIME: state_d = mtg_pkg::ST_TW_RUN;
			mtg_pkg::ST_TW_RUN: begin
				if (iss_q == mtg_pkg::POS_END && !tv_s1) begin
					state_d = mtg_pkg::ST_DRAW;
				end
			end
			mtg_pkg::ST_FETCH: begin
				if (func_q == mtg_pkg::FUNC_WORD || sec_q) begin
					state_d = mtg_pkg::ST_OUT;
				end else begin
					state_d = mtg_pkg::ST_DRAW;
				end
			end
			mtg_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = mtg_pkg::ST_IDLE;
				end
			end
			default: state_d = mtg_pkg::ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		s_tready  = 1'b0;
		rd_a_addr = pos_q;
		rd_b_addr = iss_far;
		wr_en     = 1'b0;
		wr_addr   = sd_q;
		wr_data   = w_q;
		case (state_q)
			mtg_pkg::ST_SEED: begin
				wr_en = 1'b1;
			end
			mtg_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			mtg_pkg::ST_TW_PRIME: begin
				rd_a_addr = 10'd0;
			end
			mtg_pkg::ST_TW_RUN: begin
				rd_a_addr = iss_nxt;
				wr_en     = tv_s1;
				wr_addr   = idx_s1;
				wr_data   = tw_new;
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtg_pkg::ST_SEED;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= mtg_pkg::POS_END;
			sd_q       <= 10'd0;
			w_q        <= mtg_pkg::RESET_SEED;
			seed_q     <= mtg_pkg::RESET_SEED;
			req_q      <= 1'b0;
			func_q     <= mtg_pkg::FUNC_WORD;
			sec_q      <= 1'b0;
			iss_q      <= 10'd0;
			prime_s1   <= 1'b0;
			tv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			prime_s1 <= (state_q == mtg_pkg::ST_TW_PRIME);
			tv_s1    <= issue;
			if (issue) begin
				iss_q <= iss_q + 10'd1;
			end
			// output valid: set when a result is loaded, cleared when taken
			if (state_q == mtg_pkg::ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				mtg_pkg::ST_SEED: begin
					w_q  <= seed_next;
					sd_q <= sd_q + 10'd1;
					if (sd_q == mtg_pkg::LAST_IDX) begin
						pos_q <= mtg_pkg::POS_END;
					end
				end
				mtg_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						func_q <= s_tuser;
						sec_q  <= 1'b0;
						if (s_tuser == mtg_pkg::FUNC_RESEED) begin
							w_q    <= s_tdata;
							seed_q <= s_tdata;
							sd_q   <= 10'd0;
							req_q  <= 1'b1;
						end
					end
				end
				mtg_pkg::ST_DRAW: begin
					if (pos_q < mtg_pkg::POS_END) begin
						pos_q <= pos_q + 10'd1;
					end else begin
						iss_q <= 10'd0;
					end
				end
				mtg_pkg::ST_TW_RUN: begin
					if (iss_q == mtg_pkg::POS_END && !tv_s1) begin
						pos_q <= 10'd0;
					end
				end
				mtg_pkg::ST_FETCH: begin
					if (func_q != mtg_pkg::FUNC_WORD) begin
						sec_q <= 1'b1;
					end
				end
				mtg_pkg::ST_OUT: begin
					if (out_free) begin
						req_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// index of the word being regenerated, written in the next cycle
		if (issue) begin
			idx_s1 <= iss_q;
		end
		// previous word of the twist
		if (prime_s1 || tv_s1) begin
			cur_q <= rd_a_q;
		end
		// request result, cleared when a new request comes in
		if (state_q == mtg_pkg::ST_IDLE && s_tvalid) begin
			res_q <= 53'd0;
		end
		if (state_q == mtg_pkg::ST_FETCH) begin
			if (func_q == mtg_pkg::FUNC_WORD) begin
				res_q <= {21'd0, tempered};
			end else if (!sec_q) begin
				a_q <= tempered[31:5];
			end else begin
				res_q <= {a_q, tempered[31:6]};
			end
		end
		// output beat
		if (state_q == mtg_pkg::ST_OUT && out_free) begin
			m_tdata_q <= {3'd0, seed_q, res_q};
		end
	end

endmodule

`default_nettype wire

// ----- bench/tb_mt19937_generator_unit.sv -----
// self-checking testbench for mt19937_generator_unit: drives word, fraction,
// reseed and unused requests and checks every result against a local predictor
// depends on mtg_pkg and mt19937_generator_unit
`timescale 1ns / 1ps

module tb_mt19937_generator_unit;

	// code that the block must answer with value 0 and no state change
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// cycles with no beat on either side before the run is declared hung
	localparam int unsigned HANG_LIMIT = 6000;
	// cycles to wait after the last result for anything stray
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned MAX_PRINTED = 30;

	typedef struct packed {
		logic [1:0]  func;
		logic [52:0] value;
		logic [31:0] seed;
	} gen_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] seed_value
	logic [1:0]  s_tuser;   // [1:0] func
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // [52:0] value, [84:53] current_seed

	mt19937_generator_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// predictor state
	logic [31:0] twister [0:mtg_pkg::N_WORDS-1];
	int unsigned draw_pos;
	logic [31:0] loaded_seed;

	gen_result_t pending_results[$];

	int unsigned error_count;
	int unsigned checked_count;
	int unsigned word_count, frac_count, reseed_count, unused_count;
	int unsigned burst_left;
	int unsigned idle_cycles;
	int unsigned cycle_count;
	logic [15:0] stall_pattern;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// knuth fill of the whole state from one seed
	function automatic void load_state(input logic [31:0] s);
		logic [31:0] w;
		w = s;
		loaded_seed = s;
		for (int i = 0; i < mtg_pkg::N_WORDS; i++) begin
			twister[i] = w;
			w = mtg_pkg::SEED_MULT * (w ^ (w >> 30)) + 32'(i + 1);
		end
		draw_pos = mtg_pkg::N_WORDS;
	endfunction

	// regenerate all words in place
	function automatic void twist_state();
		logic [31:0] y;
		int unsigned nxt, far;
		for (int unsigned i = 0; i < mtg_pkg::N_WORDS; i++) begin
			nxt = (i + 1) % mtg_pkg::N_WORDS;
			far = (i + mtg_pkg::M_SHIFT) % mtg_pkg::N_WORDS;
			y = {twister[i][31], twister[nxt][30:0]};
			twister[i] = twister[far] ^ {1'b0, y[31:1]}
				^ (y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
		end
		draw_pos = 0;
	endfunction

	function automatic logic [31:0] temper_word(input logic [31:0] raw);
		logic [31:0] t;
		t = raw ^ {11'd0, raw[31:11]};
		t = t ^ ({t[24:0], 7'd0} & mtg_pkg::TEMPER_B);
		t = t ^ ({t[16:0], 15'd0} & mtg_pkg::TEMPER_C);
		return t ^ {18'd0, t[31:18]};
	endfunction

	function automatic logic [31:0] draw_word();
		logic [31:0] raw;
		if (draw_pos >= mtg_pkg::N_WORDS)
			twist_state();
		raw = twister[draw_pos];
		draw_pos++;
		return temper_word(raw);
	endfunction

	// expected result of one request, advancing the predictor state
	function automatic gen_result_t predict_result(input logic [1:0] func,
			input logic [31:0] seed);
		gen_result_t r;
		logic [31:0] a, b;
		r.func = func;
		r.value = '0;
		case (func)
			mtg_pkg::FUNC_WORD: begin
				r.value = {21'd0, draw_word()};
			end
			mtg_pkg::FUNC_FRAC: begin
				a = draw_word();
				b = draw_word();
				r.value = {a[31:5], b[31:6]};
			end
			mtg_pkg::FUNC_RESEED: begin
				load_state(seed);
			end
			default: begin
			end
		endcase
		r.seed = loaded_seed;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// one request beat; valid stays high for a following beat
	task automatic send_request(input logic [1:0] func, input logic [31:0] seed);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= seed;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_result(func, seed));
		case (func)
			mtg_pkg::FUNC_WORD:   word_count++;
			mtg_pkg::FUNC_FRAC:   frac_count++;
			mtg_pkg::FUNC_RESEED: reseed_count++;
			default:              unused_count++;
		endcase
	endtask

	task automatic hold_sender(input int unsigned n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom();
			s_tuser <= 2'($urandom_range(0, 3));
			repeat (n) @(posedge clk);
		end
	endtask

	// bursts of random length, random gaps between them
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 60);
			if ($urandom_range(0, 3) != 0)
				hold_sender($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6));
		end
	endtask

	// sender waits for every outstanding result
	task automatic drain_results();
		if (pending_results.size() != 0) begin
			s_tvalid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	function automatic logic [1:0] pick_func();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 58)
			return mtg_pkg::FUNC_WORD;
		else if (roll < 92)
			return mtg_pkg::FUNC_FRAC;
		else if (roll < 95)
			return mtg_pkg::FUNC_RESEED;
		return FUNC_UNUSED;
	endfunction

	// corners: first draw after reset, every code, extreme seeds
	task automatic test_directed_corners();
		send_request(mtg_pkg::FUNC_WORD, 32'hffffffff);
		send_request(mtg_pkg::FUNC_FRAC, 32'h00000000);
		send_request(FUNC_UNUSED, 32'hffffffff);
		send_request(mtg_pkg::FUNC_WORD, 32'h00000000);
		send_request(mtg_pkg::FUNC_RESEED, 32'h00000000);
		send_request(FUNC_UNUSED, 32'h00000000);
		send_request(mtg_pkg::FUNC_WORD, 32'hffffffff);
		send_request(mtg_pkg::FUNC_FRAC, 32'hffffffff);
		hold_sender(3);
		send_request(mtg_pkg::FUNC_RESEED, 32'hffffffff);
		send_request(mtg_pkg::FUNC_FRAC, 32'h5555aaaa);
		send_request(mtg_pkg::FUNC_WORD, 32'haaaa5555);
		send_request(mtg_pkg::FUNC_RESEED, 32'h00000001);
		send_request(mtg_pkg::FUNC_RESEED, 32'h80000000);
		send_request(mtg_pkg::FUNC_FRAC, 32'h00000000);
		send_request(FUNC_UNUSED, 32'h12345678);
		send_request(mtg_pkg::FUNC_RESEED, mtg_pkg::RESET_SEED);
		send_request(mtg_pkg::FUNC_WORD, 32'h0);
		send_request(mtg_pkg::FUNC_FRAC, 32'h0);
		drain_results();
	endtask

	// a fraction whose two draws straddle the end of the state
	task automatic test_boundary_fraction();
		send_request(mtg_pkg::FUNC_RESEED, $urandom());
		for (int i = 0; i < mtg_pkg::N_WORDS - 1; i++) begin
			send_request(mtg_pkg::FUNC_WORD, $urandom());
			pace_sender();
		end
		send_request(mtg_pkg::FUNC_FRAC, $urandom());
		send_request(mtg_pkg::FUNC_WORD, $urandom());
		drain_results();
	endtask

	// random mix with periodic full drains
	task automatic test_random_mix(input int unsigned count);
		logic [1:0]  func;
		logic [31:0] seed;
		for (int unsigned i = 0; i < count; i++) begin
			func = pick_func();
			seed = $urandom();
			if (func == mtg_pkg::FUNC_RESEED && $urandom_range(0, 7) == 0)
				seed = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
			send_request(func, seed);
			if (i % 250 == 249)
				drain_results();
			else
				pace_sender();
		end
		drain_results();
	endtask

	// receiver stall pattern, periodically reshuffled; zero means no stall
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 128 == 0)
			stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'h0000
				: 16'($urandom() & $urandom());
		m_tready <= !stall_pattern[cycle_count % 16];
	end

	// result checking
	always @(posedge clk) begin : result_check
		gen_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending", 64'(m_tdata[52:0]), 64'd0);
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (m_tdata[52:0] !== want.value)
					report_mismatch($sformatf("value (func %0d)", want.func),
						64'(m_tdata[52:0]), 64'(want.value));
				if (m_tdata[84:53] !== want.seed)
					report_mismatch($sformatf("current_seed (func %0d)", want.func),
						64'(m_tdata[84:53]), 64'(want.seed));
			end
		end
	end

	// hang detection
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results pending",
				idle_cycles, pending_results.size());
			$display("FAIL mt19937_generator_unit");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= mtg_pkg::FUNC_WORD;
		m_tready <= 1'b0;
		stall_pattern <= '0;
		cycle_count <= 0;
		idle_cycles <= 0;
		error_count = 0;
		checked_count = 0;
		word_count = 0;
		frac_count = 0;
		reseed_count = 0;
		unused_count = 0;
		burst_left = 0;
		load_state(mtg_pkg::RESET_SEED);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_boundary_fraction();
		test_random_mix(1000);

		s_tvalid <= 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d word, %0d fraction, %0d reseed and %0d unused requests",
			word_count, frac_count, reseed_count, unused_count);
		$display("%0d results checked, %0d mismatches", checked_count, error_count);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("PASS mt19937_generator_unit");
		end else begin
			$display("FAIL mt19937_generator_unit");
		end
		$finish;
	end

endmodule

// ----- mt19937_generator_unit.f -----
rtl/mtg_pkg.sv
rtl/mt19937_generator_unit.sv
bench/tb_mt19937_generator_unit.sv
